@@ rtl/hbd_pkg.sv @@
// Package for the Huffman bit decoder: widths, constants, codes and shared types.
package hbd_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_CODE_LEN  = 16;
  localparam int CELL_ENTRIES  = 16;
  localparam int NUM_CELLS     = (TABLE_ENTRIES + CELL_ENTRIES - 1) / CELL_ENTRIES;

  localparam int BYTE_BITS = 8;
  localparam int IDX_W     = 8;
  localparam int CODE_W    = 16;
  localparam int ELEN_W    = 5;
  localparam int SYM_W     = 8;
  localparam int NBITS_W   = 4;
  localparam int CNT_W     = $clog2(BYTE_BITS);
  localparam int SLOT_W    = $clog2(CELL_ENTRIES);
  localparam int CSEL_W    = IDX_W - SLOT_W;

  // running code holds at most MAX_CODE_LEN bits but is compared against 16-bit codes
  localparam int RC_W   = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int RL_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int CMPL_W = (RL_W > ELEN_W) ? RL_W : ELEN_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_RESOLVE,
    ST_FLUSH
  } hbd_state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] code;
    logic [ELEN_W-1:0] len;
    logic [SYM_W-1:0]  sym;
  } hbd_load_t;

  typedef struct packed {
    logic [RC_W-1:0]   code;
    logic [CMPL_W-1:0] len;
  } hbd_key_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] sym;
  } hbd_match_t;

endpackage

@@ rtl/hbd_cell.sv @@
// One cell of the code table: a slice of entries, a local match and a link in the match chain.
module hbd_cell
  import hbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hbd_load_t  ld,
  input  hbd_key_t   key,
  input  hbd_match_t chain_in,
  output hbd_match_t chain_out
);

  logic [ELEN_W-1:0] len_r  [CELL_ENTRIES];
  logic [CODE_W-1:0] code_r [CELL_ENTRIES];
  logic [SYM_W-1:0]  sym_r  [CELL_ENTRIES];

  hbd_match_t loc_nxt;
  hbd_match_t loc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < CELL_ENTRIES; e++) begin
        len_r[e] <= '0;
      end
    end else if (ld.en) begin
      len_r[ld.slot] <= ld.len;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.en) begin
      code_r[ld.slot] <= ld.code;
      sym_r[ld.slot]  <= ld.sym;
    end
  end

  // lowest slot wins, so walk down from the top
  always_comb begin
    loc_nxt = '0;
    for (int e = CELL_ENTRIES - 1; e >= 0; e--) begin
      if (len_r[e] != '0 && CMPL_W'(len_r[e]) == key.len && RC_W'(code_r[e]) == key.code) begin
        loc_nxt.hit = 1'b1;
        loc_nxt.sym = sym_r[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r <= '0;
    end else begin
      loc_r <= loc_nxt;
    end
  end

  // lower cells take priority over everything passed down from higher ones
  assign chain_out = loc_r.hit ? loc_r : chain_in;

endmodule

@@ rtl/huffman_bit_decoder.sv @@
// Huffman bit decoder: loadable code table held in a row of match cells, bit-serial decode.
// A load leaves busy low, as does an item with no valid bits.
// A data item of n valid bits (capped at 8) keeps busy high: each bit takes a cell compare
// step (ST_LOOK) and a chain resolve step (ST_RESOLVE), plus a flush step (ST_FLUSH) when a
// result is still to be sent. Results leave from registers, the last one in the cycle busy
// falls; receiver cannot stall. Synchronous active-low reset clears every table length (all
// entries invalid) and the running code; no clearing pass is needed.
module huffman_bit_decoder
  import hbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [IDX_W-1:0]   in_entry_index,
  input  logic [CODE_W-1:0]  in_entry_code,
  input  logic [ELEN_W-1:0]  in_entry_length,
  input  logic [SYM_W-1:0]   in_entry_symbol,
  input  logic [7:0]         in_data_byte,
  input  logic [NBITS_W-1:0] in_bits_valid,
  output logic               out_valid,
  output logic [SYM_W-1:0]   out_symbol,
  output logic               out_overflow,
  output logic               out_last
);

  hbd_state_t state_r, state_nxt;

  logic [RC_W-1:0]      rc_r, rc_nxt;
  logic [RL_W-1:0]      rl_r, rl_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0]     pend_sym_r, pend_sym_nxt;
  logic                 pend_ovf_r, pend_ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]     out_symbol_r, out_symbol_nxt;
  logic                 out_overflow_r, out_overflow_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept;
  logic                 go_decode;
  logic [NBITS_W-1:0]   nbits;
  logic                 res_hit;
  logic                 res_ovf;
  logic                 res_any;
  logic [RC_W-1:0]      base_rc;
  logic [RL_W-1:0]      base_rl;

  hbd_key_t   key;
  hbd_match_t chain [NUM_CELLS+1];

  assign accept    = start && (state_r == ST_IDLE);
  assign nbits     = (in_bits_valid > NBITS_W'(BYTE_BITS)) ? NBITS_W'(BYTE_BITS) : in_bits_valid;
  assign go_decode = accept && (in_opcode == OP_DECODE) && (nbits != '0);

  assign key.code = rc_r;
  assign key.len  = CMPL_W'(rl_r);

  assign chain[NUM_CELLS] = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    hbd_load_t ld;
    assign ld.en   = accept && (in_opcode == OP_LOAD)
                  && ({1'b0, in_entry_index} < (IDX_W+1)'(TABLE_ENTRIES))
                  && (in_entry_index[IDX_W-1:SLOT_W] == CSEL_W'(i));
    assign ld.slot = in_entry_index[SLOT_W-1:0];
    assign ld.code = in_entry_code;
    assign ld.len  = in_entry_length;
    assign ld.sym  = in_entry_symbol;

    hbd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ld        (ld),
      .key       (key),
      .chain_in  (chain[i+1]),
      .chain_out (chain[i])
    );
  end

  assign res_hit = chain[0].hit;
  assign res_ovf = !res_hit && (rl_r >= RL_W'(MAX_CODE_LEN));
  assign res_any = res_hit || res_ovf;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_decode) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (cnt_r != '0) begin
          state_nxt = ST_LOOK;
        end else if (pend_v_r || res_any) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs; a result is held back one step so the item's final one gets last
  always_comb begin
    rc_nxt           = rc_r;
    rl_nxt           = rl_r;
    byte_nxt         = byte_r;
    cnt_nxt          = cnt_r;
    pend_v_nxt       = pend_v_r;
    pend_sym_nxt     = pend_sym_r;
    pend_ovf_nxt     = pend_ovf_r;
    out_valid_nxt    = 1'b0;
    out_symbol_nxt   = out_symbol_r;
    out_overflow_nxt = out_overflow_r;
    out_last_nxt     = out_last_r;
    base_rc          = rc_r;
    base_rl          = rl_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_decode) begin
          rc_nxt   = {rc_r[RC_W-2:0], in_data_byte[7]};
          rl_nxt   = rl_r + RL_W'(1);
          byte_nxt = {in_data_byte[6:0], 1'b0};
          cnt_nxt  = CNT_W'(nbits - NBITS_W'(1));
        end
      end
      ST_LOOK: begin
      end
      ST_RESOLVE: begin
        if (res_any) begin
          base_rc = '0;
          base_rl = '0;
          if (pend_v_r) begin
            out_valid_nxt    = 1'b1;
            out_symbol_nxt   = pend_sym_r;
            out_overflow_nxt = pend_ovf_r;
            out_last_nxt     = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_sym_nxt = res_hit ? chain[0].sym : '0;
          pend_ovf_nxt = res_ovf;
        end
        if (cnt_r != '0) begin
          rc_nxt   = {base_rc[RC_W-2:0], byte_r[7]};
          rl_nxt   = base_rl + RL_W'(1);
          byte_nxt = {byte_r[6:0], 1'b0};
          cnt_nxt  = cnt_r - CNT_W'(1);
        end else begin
          rc_nxt = base_rc;
          rl_nxt = base_rl;
        end
      end
      ST_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt    = 1'b1;
          out_symbol_nxt   = pend_sym_r;
          out_overflow_nxt = pend_ovf_r;
          out_last_nxt     = 1'b1;
        end
        pend_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rc_r        <= '0;
      rl_r        <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      rl_r        <= rl_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r         <= byte_nxt;
    pend_sym_r     <= pend_sym_nxt;
    pend_ovf_r     <= pend_ovf_nxt;
    out_symbol_r   <= out_symbol_nxt;
    out_overflow_r <= out_overflow_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_symbol   = out_symbol_r;
  assign out_overflow = out_overflow_r;
  assign out_last     = out_last_r;

`ifndef NO_ASSERTIONS
  a_ovf_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_symbol == '0)
    else $error("overflow transfer carries a nonzero symbol");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("decoder still busy after final transfer of an item");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && pend_v_r)
    else $error("non-final transfer with no result left to send");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rl_r <= RL_W'(MAX_CODE_LEN))
    else $error("running code length beyond maximum");
`endif

endmodule

@@ bench/huffman_bit_decoder_tb.sv @@
// Self-checking bench for the Huffman bit decoder: table loads and bit-serial decode.
`timescale 1ns / 100ps

module huffman_bit_decoder_tb;
  import hbd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int NUM_PHASES = 6;
  localparam int DECODES_PER_PHASE = 55;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             overflow;
    logic             last;
  } decode_result_t;

  // Tracks table contents and the running code; holds the results still owed.
  class decode_scoreboard;
    logic [CODE_W-1:0] code_tab [TABLE_ENTRIES];
    logic [ELEN_W-1:0] len_tab [TABLE_ENTRIES];
    logic [SYM_W-1:0]  sym_tab [TABLE_ENTRIES];
    logic [RC_W-1:0]   run_code;
    int                run_len;
    decode_result_t    expected_q [$];
    int                errors;

    function new();
      foreach (len_tab[k]) begin
        code_tab[k] = '0;
        len_tab[k]  = '0;
        sym_tab[k]  = '0;
      end
      run_code = '0;
      run_len  = 0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic op, logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code,
                            logic [ELEN_W-1:0] len, logic [SYM_W-1:0] sym,
                            logic [7:0] data, logic [NBITS_W-1:0] nbits);
      int nb;
      int hit;
      bit have_prev;
      decode_result_t prev;
      decode_result_t r;
      if (op == OP_LOAD) begin
        if (idx < TABLE_ENTRIES) begin
          code_tab[idx] = code;
          len_tab[idx]  = len;
          sym_tab[idx]  = sym;
        end
        return;
      end
      nb = (nbits > BYTE_BITS) ? BYTE_BITS : int'(nbits);
      have_prev = 1'b0;
      for (int i = 0; i < nb; i++) begin
        run_code = {run_code[RC_W-2:0], data[BYTE_BITS-1-i]};
        run_len++;
        hit = -1;
        for (int k = 0; k < TABLE_ENTRIES && hit < 0; k++)
          if (len_tab[k] != 0 && int'(len_tab[k]) == run_len && code_tab[k] == run_code)
            hit = k;
        if (hit >= 0 || run_len >= MAX_CODE_LEN) begin
          r.symbol   = (hit >= 0) ? sym_tab[hit] : '0;
          r.overflow = (hit < 0);
          r.last     = 1'b0;
          if (have_prev) expected_q.push_back(prev);
          prev      = r;
          have_prev = 1'b1;
          run_code  = '0;
          run_len   = 0;
        end
      end
      if (have_prev) begin
        prev.last = 1'b1;
        expected_q.push_back(prev);
      end
    endfunction

    task report_mismatch(string what);
      if (errors < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [SYM_W-1:0] sym, logic ovf, logic lst);
      decode_result_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sym=%02h ovf=%0b last=%0b", sym, ovf, lst));
        return;
      end
      exp_r = expected_q.pop_front();
      if (sym !== exp_r.symbol)
        report_mismatch($sformatf("symbol %02h, wanted %02h", sym, exp_r.symbol));
      if (ovf !== exp_r.overflow)
        report_mismatch($sformatf("overflow %0b, wanted %0b", ovf, exp_r.overflow));
      if (lst !== exp_r.last)
        report_mismatch($sformatf("last %0b, wanted %0b", lst, exp_r.last));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_opcode;
  logic [IDX_W-1:0]   in_entry_index;
  logic [CODE_W-1:0]  in_entry_code;
  logic [ELEN_W-1:0]  in_entry_length;
  logic [SYM_W-1:0]   in_entry_symbol;
  logic [7:0]         in_data_byte;
  logic [NBITS_W-1:0] in_bits_valid;
  logic               out_valid;
  logic [SYM_W-1:0]   out_symbol;
  logic               out_overflow;
  logic               out_last;

  decode_scoreboard sb;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [CODE_W-1:0] good_code [$];
  int                good_len [$];
  bit                code_bits [$];

  huffman_bit_decoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_entry_code  (in_entry_code),
    .in_entry_length(in_entry_length),
    .in_entry_symbol(in_entry_symbol),
    .in_data_byte   (in_data_byte),
    .in_bits_valid  (in_bits_valid),
    .out_valid      (out_valid),
    .out_symbol     (out_symbol),
    .out_overflow   (out_overflow),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result capture and watchdog; values read here are those before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result(out_symbol, out_overflow, out_last);
    if ((start && !busy) || out_valid === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // start is left high on return so that a following item can go back to back
  task automatic drive_item(logic op, logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code,
                            logic [ELEN_W-1:0] len, logic [SYM_W-1:0] sym,
                            logic [7:0] data, logic [NBITS_W-1:0] nbits);
    in_opcode       <= op;
    in_entry_index  <= idx;
    in_entry_code   <= code;
    in_entry_length <= len;
    in_entry_symbol <= sym;
    in_data_byte    <= data;
    in_bits_valid   <= nbits;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, idx, code, len, sym, data, nbits);
  endtask

  task automatic load_entry(logic [IDX_W-1:0] idx, logic [CODE_W-1:0] code,
                            logic [ELEN_W-1:0] len, logic [SYM_W-1:0] sym);
    drive_item(OP_LOAD, idx, code, len, sym, 8'($urandom), NBITS_W'($urandom));
  endtask

  task automatic decode_byte(logic [7:0] data, logic [NBITS_W-1:0] nbits);
    drive_item(OP_DECODE, IDX_W'($urandom), CODE_W'($urandom), ELEN_W'($urandom),
               SYM_W'($urandom), data, nbits);
  endtask

  // Sender bursts; roughly one burst in four follows the last without a gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    if ($urandom_range(0, 3) == 0) return;
    gap = $urandom_range(1, 30);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly usable codes; some invalid, over-long or with stray high code bits.
  task automatic load_random_entry();
    int len;
    logic [CODE_W-1:0] code;
    code = CODE_W'($urandom);
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = $urandom_range(MAX_CODE_LEN + 1, (1 << ELEN_W) - 1);
      2: len = $urandom_range(1, 8);
      default: begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, MAX_CODE_LEN)
                                         : $urandom_range(1, 6);
        code = code & CODE_W'((32'd1 << len) - 1);
        good_code.push_back(code);
        good_len.push_back(len);
      end
    endcase
    load_entry(IDX_W'($urandom), code, ELEN_W'(len), SYM_W'($urandom));
  endtask

  // Builds a fresh set of codes, then feeds a bit stream made from them.
  task automatic run_phase();
    int nloads;
    int nb;
    int j;
    logic [7:0] data;
    good_code.delete();
    good_len.delete();
    nloads = $urandom_range(10, 24);
    for (int n = 0; n < nloads; n++) begin
      load_random_entry();
      pace();
    end
    for (int n = 0; n < DECODES_PER_PHASE; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        load_random_entry();
      end else if ($urandom_range(0, 9) == 0) begin
        decode_byte(8'($urandom), NBITS_W'($urandom_range(0, (1 << NBITS_W) - 1)));
      end else begin
        nb = $urandom_range(1, BYTE_BITS);
        data = 8'($urandom);
        for (int i = 0; i < nb; i++) begin
          if (code_bits.size() == 0) begin
            if (good_len.size() == 0) begin
              code_bits.push_back(1'($urandom_range(0, 1)));
            end else begin
              j = $urandom_range(0, good_len.size() - 1);
              for (int b = good_len[j] - 1; b >= 0; b--) code_bits.push_back(good_code[j][b]);
            end
          end
          data[BYTE_BITS-1-i] = code_bits.pop_front();
        end
        decode_byte(data, NBITS_W'(nb));
      end
      pace();
    end
  endtask

  initial begin
    sb = new();
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= OP_LOAD;
    in_entry_index  <= '0;
    in_entry_code   <= '0;
    in_entry_length <= '0;
    in_entry_symbol <= '0;
    in_data_byte    <= '0;
    in_bits_valid   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: eight ones pend, then zeros run the code out to an overflow
    decode_byte(8'hFF, 4'd8);
    decode_byte(8'h00, 4'd8);
    load_entry(8'd0, 16'h0000, 5'd1, 8'hFF);
    load_entry(8'd255, 16'hFFFF, 5'd16, 8'h00);
    // same code twice: the lower slot must win
    load_entry(8'd1, 16'h0002, 5'd2, 8'h5A);
    load_entry(8'd2, 16'h0002, 5'd2, 8'hA5);
    // stray bit above the length: never matches
    load_entry(8'd3, 16'h8003, 5'd2, 8'h11);
    // longer than the running code can get
    load_entry(8'd4, 16'h0000, 5'd31, 8'h22);
    load_entry(8'd5, 16'h7FFF, 5'd17, 8'h33);
    decode_byte(8'h00, 4'd0);
    decode_byte(8'hFF, 4'd15);
    decode_byte(8'hFF, 4'd8);
    decode_byte(8'h80, 4'd2);
    decode_byte(8'h00, 4'd8);
    load_entry(8'd0, 16'h0000, 5'd0, 8'h00);
    // a load between two halves of a code leaves the running code alone
    decode_byte(8'h00, 4'd1);
    load_entry(8'd6, 16'h0001, 5'd2, 8'hC3);
    decode_byte(8'h80, 4'd1);
    decode_byte(8'hBF, 4'd8);
    decode_byte(8'h55, 4'd4);
    load_entry(8'd128, 16'h5555, 5'd16, 8'h80);
    decode_byte(8'h55, 4'd8);
    decode_byte(8'h55, 4'd8);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      run_phase();
      wait_drained();
    end
    repeat (40) @(posedge clk);

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
